FILE: hdl/assert_macros.svh
// Assertion helpers used by the generator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hdl/fpwg_pkg.sv
package fpwg_pkg;

    // Default sizes.
    localparam int unsigned DEF_SINE_TABLE_DEPTH = 1024;
    localparam int unsigned DEF_FORCE_WIDTH      = 16;

    // Fixed field widths.
    localparam int unsigned TICK_W     = 32;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 2;

    // Profile mode codes; the last one is not assigned and answers zero.
    localparam logic [1:0] MODE_STEP     = 2'd0;
    localparam logic [1:0] MODE_TRIANGLE = 2'd1;
    localparam logic [1:0] MODE_SINE     = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PROFILE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_FORCE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DURATION     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 2'd3;

    // Duration limits and reset value.
    localparam logic [TICK_W-1:0] MIN_DURATION = 32'd1000;
    localparam logic [TICK_W-1:0] RST_DURATION = 32'd1000000;

    // Q30 sine polynomial, sin(pi/2 * x) for x in 0..1.
    typedef logic [30:0] t_q30;
    localparam t_q30 Q30_ONE = 31'h4000_0000;
    localparam t_q30 SIN_C1  = 31'd1686629713;
    localparam t_q30 SIN_C3  = 31'd693598670;
    localparam t_q30 SIN_C5  = 31'd85569306;
    localparam t_q30 SIN_C7  = 31'd5026994;
    localparam t_q30 SIN_C9  = 31'd172272;

    // Register stages of the sine path, phase multiply through force scaling.
    localparam int unsigned SIN_STAGES = 9;

endpackage

FILE: hdl/force_profile_waveform_generator_core.sv
// Force profile generator: every elapsed-time transaction yields one target force for the
// configured profile (step hold, triangle ramp or clamped sinusoid). The block takes one
// transaction per clock when no stall holds the pipeline and returns results in order. The
// pipeline depth is set by the triangle divider, which resolves one quotient bit per pipeline
// stage (FORCE_WIDTH stages behind the ramp-factor and peak-multiply stages); the sine path
// (phase multiply, polynomial sine evaluation, force scaling) runs in parallel and is delayed
// to match. Stalls propagate stage by stage, so empty stages keep filling while a finished
// result waits at the output. The user must write configuration through the write port only
// while no transaction is in flight; the block itself does not enforce this.
`include "assert_macros.svh"

module force_profile_waveform_generator_core #(
    parameter int unsigned SINE_TABLE_DEPTH = fpwg_pkg::DEF_SINE_TABLE_DEPTH,
    parameter int unsigned FORCE_WIDTH      = fpwg_pkg::DEF_FORCE_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fpwg_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fpwg_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [fpwg_pkg::TICK_W-1:0]      i_elapsed_ticks,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [FORCE_WIDTH-1:0]           o_target_force
);

    localparam int unsigned FW     = FORCE_WIDTH;
    localparam int unsigned TW     = fpwg_pkg::TICK_W;
    localparam int unsigned IDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned NSTG   = FW + 2;
    localparam int unsigned SN_DLY = NSTG - fpwg_pkg::SIN_STAGES;
    localparam int unsigned PROD_W = FW + TW;

    // Configuration registers.
    logic [1:0]    r_mode;
    logic [FW-1:0] r_peak;
    logic [TW-1:0] r_dur;
    logic [TW-1:0] r_pstep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= fpwg_pkg::MODE_STEP;
            r_peak  <= '0;
            r_dur   <= fpwg_pkg::RST_DURATION;
            r_pstep <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fpwg_pkg::REG_PROFILE_MODE: r_mode <= i_cfg_wdata[1:0];
                fpwg_pkg::REG_PEAK_FORCE:   r_peak <= i_cfg_wdata[FW-1:0];
                fpwg_pkg::REG_DURATION: begin
                    r_dur <= (i_cfg_wdata < fpwg_pkg::MIN_DURATION) ?
                             fpwg_pkg::MIN_DURATION : i_cfg_wdata;
                end
                fpwg_pkg::REG_PHASE_STEP:   r_pstep <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage-by-stage flow control: a stage loads when it is empty or its successor loads.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;
    logic            w_out_en;
    logic            r_ov;
    logic [FW-1:0]   r_force;

    assign w_out_en = !r_ov || !i_out_stall;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || w_out_en;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_in_stall = !w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 0: step compare, triangle ramp factor and sine phase.
    logic          w_rise;
    logic [TW-1:0] w_half;
    logic [TW-1:0] w_phase;

    assign w_rise  = {i_elapsed_ticks, 1'b0} <= {1'b0, r_dur};
    assign w_half  = w_rise ? i_elapsed_ticks : (r_dur - i_elapsed_ticks);
    assign w_phase = r_pstep * i_elapsed_ticks;

    logic [NSTG-1:0] r_st;
    logic [NSTG-1:0] r_tr_act;
    logic [TW-1:0]   r_tr_half;
    logic [TW-1:0]   r_sn_phase;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_st[0]     <= i_elapsed_ticks <= r_dur;
            r_tr_act[0] <= i_elapsed_ticks < r_dur;
            r_tr_half   <= w_half;
            r_sn_phase  <= w_phase;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (w_en[k]) begin
                r_st[k]     <= r_st[k-1];
                r_tr_act[k] <= r_tr_act[k-1];
            end
        end
    end

    // Stage 1: peak times half the ramp factor; the factor's doubling is a shift.
    logic [PROD_W-1:0] r_tr_prod;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_tr_prod <= PROD_W'(r_peak) * PROD_W'(r_tr_half);
        end
    end

    // Stages 2 onward: restoring division of 2*prod by duration, one quotient bit a stage.
    // The quotient never exceeds peak, so the numerator's upper part starts below duration.
    logic [TW-1:0] r_dv_rem [FW];
    logic [FW-1:0] r_dv_quo [FW];
    logic [FW-1:0] r_dv_low [FW];

    for (genvar j = 0; j < FW; j++) begin : g_div
        logic [TW-1:0] w_rem_in;
        logic [FW-1:0] w_quo_in;
        logic [FW-1:0] w_low_in;
        logic [TW:0]   w_r2;
        logic [TW:0]   w_diff;
        logic          w_ge;

        if (j == 0) begin : g_first
            assign w_rem_in = r_tr_prod[FW+TW-2:FW-1];
            assign w_quo_in = '0;
            assign w_low_in = {r_tr_prod[FW-2:0], 1'b0};
        end else begin : g_next
            assign w_rem_in = r_dv_rem[j-1];
            assign w_quo_in = r_dv_quo[j-1];
            assign w_low_in = r_dv_low[j-1];
        end

        assign w_r2   = {w_rem_in, w_low_in[FW-1]};
        assign w_ge   = w_r2 >= {1'b0, r_dur};
        assign w_diff = w_r2 - {1'b0, r_dur};

        always_ff @(posedge i_clk) begin
            if (w_en[j+2]) begin
                r_dv_rem[j] <= w_ge ? w_diff[TW-1:0] : w_r2[TW-1:0];
                r_dv_quo[j] <= {w_quo_in[FW-2:0], w_ge};
                r_dv_low[j] <= {w_low_in[FW-2:0], 1'b0};
            end
        end
    end

    // Sine stage 1: quadrant, mirrored Q30 angle and its square.
    logic [TW-1:0]        w_praw;
    fpwg_pkg::t_q30       w_x0;
    fpwg_pkg::t_q30       w_x;
    logic [61:0]          w_xx;

    assign w_praw = {r_sn_phase[TW-1 -: IDX_W], {(TW - IDX_W){1'b0}}};
    assign w_x0   = {1'b0, w_praw[29:0]};
    assign w_x    = w_praw[30] ? (fpwg_pkg::Q30_ONE - w_x0) : w_x0;
    assign w_xx   = 62'(w_x) * 62'(w_x);

    fpwg_pkg::t_q30 r_sn_x    [1:5];
    logic [1:0]     r_sn_quad [1:6];
    fpwg_pkg::t_q30 r_sn_x2   [1:4];
    fpwg_pkg::t_q30 r_sn_r    [2:5];

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_sn_x[1]    <= w_x;
            r_sn_quad[1] <= w_praw[31:30];
            r_sn_x2[1]   <= w_xx[60:30];
        end
        for (int s = 2; s <= 6; s++) begin
            if (w_en[s]) begin
                r_sn_quad[s] <= r_sn_quad[s-1];
            end
        end
        for (int s = 2; s <= 5; s++) begin
            if (w_en[s]) begin
                r_sn_x[s] <= r_sn_x[s-1];
            end
        end
        for (int s = 2; s <= 4; s++) begin
            if (w_en[s]) begin
                r_sn_x2[s] <= r_sn_x2[s-1];
            end
        end
    end

    // Sine stages 2 to 5: Horner steps of the odd polynomial, one multiply each.
    for (genvar j = 0; j < 4; j++) begin : g_horner
        localparam fpwg_pkg::t_q30 COEF = (j == 0) ? fpwg_pkg::SIN_C7 :
                                          (j == 1) ? fpwg_pkg::SIN_C5 :
                                          (j == 2) ? fpwg_pkg::SIN_C3 : fpwg_pkg::SIN_C1;
        fpwg_pkg::t_q30 w_rin;
        logic [61:0]    w_term;

        if (j == 0) begin : g_first
            assign w_rin = fpwg_pkg::SIN_C9;
        end else begin : g_next
            assign w_rin = r_sn_r[j+1];
        end

        assign w_term = 62'(r_sn_x2[j+1]) * 62'(w_rin);

        always_ff @(posedge i_clk) begin
            if (w_en[j+2]) begin
                r_sn_r[j+2] <= COEF - w_term[60:30];
            end
        end
    end

    // Sine stage 6: y = x * polynomial, Q30.
    logic [61:0]    w_y;
    fpwg_pkg::t_q30 r_sn_y;

    assign w_y = 62'(r_sn_x[5]) * 62'(r_sn_r[5]);

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_sn_y <= w_y[60:30];
        end
    end

    // Sine stage 7: round to Q15, saturate, apply sign and offset to unsigned 1..65535.
    logic [31:0] w_rnd;
    logic [14:0] w_q15;
    logic [15:0] r_sn_u;

    assign w_rnd = {1'b0, r_sn_y} + 32'd16384;
    assign w_q15 = (w_rnd[31:30] != 2'b00) ? 15'h7fff : w_rnd[29:15];

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_sn_u <= r_sn_quad[6][1] ? (16'h8000 - {1'b0, w_q15}) : (16'h8000 + {1'b0, w_q15});
        end
    end

    // Sine stage 8: scale by peak; the offset sine stays below 2^16, so no clamp is needed.
    logic [FW+15:0] w_sn_scaled;
    logic [FW-1:0]  r_sn_force;
    logic [FW-1:0]  r_sn_dly [SN_DLY];

    assign w_sn_scaled = (FW + 16)'(r_peak) * (FW + 16)'(r_sn_u);

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r_sn_force <= w_sn_scaled[FW+15:16];
        end
    end

    // Delay line that aligns the sine result with the end of the divider.
    always_ff @(posedge i_clk) begin
        if (w_en[fpwg_pkg::SIN_STAGES]) begin
            r_sn_dly[0] <= r_sn_force;
        end
        for (int i = 1; i < SN_DLY; i++) begin
            if (w_en[fpwg_pkg::SIN_STAGES + i]) begin
                r_sn_dly[i] <= r_sn_dly[i-1];
            end
        end
    end

    // Output register: pick the result of the configured profile.
    logic [FW-1:0] w_force;

    always_comb begin
        case (r_mode)
            fpwg_pkg::MODE_STEP:     w_force = r_st[NSTG-1] ? r_peak : '0;
            fpwg_pkg::MODE_TRIANGLE: w_force = r_tr_act[NSTG-1] ? r_dv_quo[FW-1] : '0;
            fpwg_pkg::MODE_SINE:     w_force = r_sn_dly[SN_DLY-1];
            default:                 w_force = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_out_en) begin
            r_ov <= r_vld[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en) begin
            r_force <= w_force;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_target_force = r_force;

    // Checks on the flow control.
    `ASSERT_CLK(a_stall_needs_full_head, o_in_stall |-> r_vld[0], "input stalled, stage empty")
    `ASSERT_CLK(a_tail_moves_out, (r_vld[NSTG-1] && w_out_en) |=> o_out_valid, "result lost")
    `ASSERT_CLK(a_out_from_tail, $rose(o_out_valid) |-> $past(r_vld[NSTG-1]), "orphan result")
    `ASSERT_CLK_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule
